@@ hw/rtl/fcf_pkg.sv @@
package fcf_pkg;

  // frame layout
  localparam int FrameLen   = 10;
  localparam int DataLen    = 8;
  localparam int IdxW       = $clog2(FrameLen);
  localparam int QueueDepth = 2;

  // byte positions of the check word within a frame
  localparam logic [IdxW-1:0] ByteCrcLo = IdxW'(DataLen);
  localparam logic [IdxW-1:0] ByteCrcHi = IdxW'(FrameLen - 1);

  // crc-16/modbus
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // one input transfer: four channel samples
  typedef struct packed {
    logic signed [15:0] sample_3;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_0;
  } fcf_in_t;

  // one result transfer: one frame byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } fcf_out_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    avail;
    fcf_in_t item;
  } fcf_head_t;

  // fold one byte into the crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/fcf_front.sv @@
module fcf_front #(
  parameter int QUEUE_DEPTH = fcf_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fcf_pkg::fcf_in_t  in_item,
  input  logic              pop,
  output fcf_pkg::fcf_head_t head
);
  import fcf_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  fcf_in_t         mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push;

  // accept a transfer whenever a slot is free
  assign busy = (count_r == CntFull);
  assign push = start && !busy;

  assign head.avail = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // sample storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

`ifndef SYNTH
  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("fill count lost a push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("fill count lost a pop");
`endif

endmodule

@@ hw/rtl/fcf_back.sv @@
module fcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  fcf_pkg::fcf_head_t head,
  output logic               pop,
  output logic               out_valid,
  output fcf_pkg::fcf_out_t  out_item
);
  import fcf_pkg::*;

  logic            active_r, active_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [63:0]     data_r, data_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic            last_byte;
  logic            in_data;

  assign last_byte = active_r && (idx_r == ByteCrcHi);
  assign in_data   = (idx_r < ByteCrcLo);

  // take the next frame when idle or on the final byte of the current one
  assign pop = head.avail && (!active_r || last_byte);

  // serialiser: one byte per cycle, crc folded in as data bytes go out
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    data_nxt   = data_r;
    crc_nxt    = crc_r;
    if (pop) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      data_nxt   = head.item;
      crc_nxt    = CrcInit;
    end else if (last_byte) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      idx_nxt = idx_r + 1'b1;
      if (in_data) begin
        crc_nxt  = crc_byte(crc_r, data_r[7:0]);
        data_nxt = data_r >> 8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    crc_r  <= crc_nxt;
  end

  // result byte select
  always_comb begin
    out_valid          = active_r;
    out_item.frame_end = last_byte;
    if (in_data) begin
      out_item.frame_byte = data_r[7:0];
    end else if (idx_r == ByteCrcLo) begin
      out_item.frame_byte = crc_r[7:0];
    end else begin
      out_item.frame_byte = crc_r[15:8];
    end
  end

`ifndef SYNTH
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.frame_end) |=> out_valid && idx_r == $past(idx_r) + 1'b1)
    else $error("gap inside a frame");

  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.frame_end |-> out_valid)
    else $error("frame end without strobe");

  a_pop_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid && idx_r == '0)
    else $error("new frame did not start at byte zero");
`endif

endmodule

@@ hw/rtl/four_channel_frame_crc16.sv @@
// channel  direction  handshake              payload
// input    in         start / busy           in_item   (fcf_in_t, four samples)
// result   out        out_valid strobe       out_item  (fcf_out_t, byte and end flag)
//
// each accepted item gives a ten-byte frame, one byte per cycle, the crc
// folded in one byte a cycle as the data bytes go out.
// with the serialiser idle the first byte is strobed once the item has passed
// through the queue into the serialiser registers; frames follow back to back
// while the queue holds items, so new items are taken while a frame goes out.
// a queue of QUEUE_DEPTH items sits ahead of the serialiser; busy is high
// only while that queue is full.
// reset clears the queue and the serialiser; the receiver cannot stall.
module four_channel_frame_crc16 #(
  parameter int QUEUE_DEPTH = fcf_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fcf_pkg::fcf_in_t  in_item,
  output logic              out_valid,
  output fcf_pkg::fcf_out_t out_item
);
  import fcf_pkg::*;

  fcf_head_t head;
  logic      pop;

  // front end: accept and queue sample sets
  fcf_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .head    (head)
  );

  // back end: serialise frame and check word
  fcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
